/* rtl/bdascii_pkg.sv */
// ----------------------------------------------------------------------------
// bdascii_pkg
// Shared constants, types and the BCD shift-and-add-3 step for the decimal
// ASCII printer.
// ----------------------------------------------------------------------------
package bdascii_pkg;

	// Only the low VALUE_WIDTH bits of the input are converted (8 to 64).
	localparam int VALUE_WIDTH = 64;
	localparam int VALUE_PORT_W = 64;
	localparam int NUM_DIGITS = 20;
	localparam int BCD_W = 4 * NUM_DIGITS;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int REM_W = $clog2(NUM_DIGITS + 1);
	localparam int CHAR_W = 6;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

	// Depth of the queue between converter and digit sequencer (power of two).
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [BCD_W-1:0] bcd_t;
	typedef logic [VALUE_WIDTH-1:0] value_t;

	// One double-dabble step: every digit of five or more gets three added,
	// then the whole word shifts left and takes in the next binary bit.
	function automatic bcd_t dabble_step(input bcd_t bcd, input logic bin_bit);
		bcd_t adj;
		logic [3:0] dig;
		adj = bcd;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			dig = bcd[4*i +: 4];
			if (dig >= 4'd5) begin
				adj[4*i +: 4] = dig + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], bin_bit};
	endfunction

endpackage

/* rtl/bdascii_front.sv */
// ----------------------------------------------------------------------------
// bdascii_front
// Accepts one binary value and converts it to packed BCD, one bit per cycle.
// ----------------------------------------------------------------------------
module bdascii_front (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic [bdascii_pkg::VALUE_PORT_W-1:0]        value,
	output logic                                        push_valid,
	input  logic                                        push_ready,
	output bdascii_pkg::bcd_t                           push_bcd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                      state_q;
	logic [bdascii_pkg::CNT_W-1:0]   cnt_q;
	bdascii_pkg::value_t             val_q;
	bdascii_pkg::bcd_t               bcd_q;
	logic                            accept;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign push_valid = (state_q == ST_DONE);
	assign push_bcd   = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
						cnt_q   <= bdascii_pkg::CNT_W'(bdascii_pkg::VALUE_WIDTH - 1);
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value[bdascii_pkg::VALUE_WIDTH-1:0];
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bcd_q <= bdascii_pkg::dabble_step(bcd_q, val_q[bdascii_pkg::VALUE_WIDTH-1]);
			val_q <= val_q << 1;
		end
	end

endmodule

/* rtl/bdascii_fifo.sv */
// ----------------------------------------------------------------------------
// bdascii_fifo
// Short queue of converted BCD words between the converter and the sequencer.
// ----------------------------------------------------------------------------
module bdascii_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  bdascii_pkg::bcd_t push_bcd,
	output logic              pop_valid,
	input  logic              pop_ready,
	output bdascii_pkg::bcd_t pop_bcd
);

	bdascii_pkg::bcd_t                  entry_q [bdascii_pkg::QUEUE_DEPTH];
	logic [bdascii_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [bdascii_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [bdascii_pkg::QCNT_W-1:0]     count_q;
	logic                               do_push;
	logic                               do_pop;

	assign push_ready = (count_q != bdascii_pkg::QCNT_W'(bdascii_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_bcd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_bcd;
		end
	end

endmodule

/* rtl/bdascii_back.sv */
// ----------------------------------------------------------------------------
// bdascii_back
// Walks a BCD word from the top digit down, skips leading zeros and sends
// one ASCII digit per request through an output register.
// ----------------------------------------------------------------------------
module bdascii_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  bdascii_pkg::bcd_t                    pop_bcd,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [bdascii_pkg::CHAR_W-1:0]       digit_char,
	output logic                                 last
);

	bdascii_pkg::bcd_t                  bcd_q;
	logic [bdascii_pkg::REM_W-1:0]      rem_q;
	logic                               busy_q;
	logic                               started_q;
	logic                               out_valid_q;
	logic [bdascii_pkg::CHAR_W-1:0]     char_q;
	logic                               last_q;
	logic [3:0]                         top_digit;
	logic                               final_digit;
	logic                               slot_free;
	logic                               skip;
	logic                               emit;

	assign top_digit   = bcd_q[bdascii_pkg::BCD_W-1 -: 4];
	assign final_digit = (rem_q == bdascii_pkg::REM_W'(1));
	assign slot_free   = !out_valid_q || out_ready;
	// The last digit is always sent, so a zero value still gives one '0'.
	assign skip        = busy_q && !started_q && (top_digit == 4'd0) && !final_digit;
	assign emit        = busy_q && !skip && slot_free;
	assign pop_ready   = !busy_q;

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			started_q   <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				if (pop_valid) begin
					busy_q    <= 1'b1;
					started_q <= 1'b0;
					rem_q     <= bdascii_pkg::REM_W'(bdascii_pkg::NUM_DIGITS);
				end
			end else if (skip || emit) begin
				rem_q <= rem_q - 1'b1;
				if (emit) begin
					started_q <= 1'b1;
					if (final_digit) begin
						busy_q <= 1'b0;
					end
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && pop_valid) begin
			bcd_q <= pop_bcd;
		end else if (skip || emit) begin
			bcd_q <= {bcd_q[bdascii_pkg::BCD_W-5:0], 4'd0};
		end
		if (emit) begin
			char_q <= bdascii_pkg::ASCII_ZERO + {2'b00, top_digit};
			last_q <= final_digit;
		end
	end

endmodule

/* rtl/binary_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Prints an unsigned binary value as decimal ASCII digits, most significant
// first, without leading zeros.
// ----------------------------------------------------------------------------
// A request on the input carries one value; the block answers with one output
// request per decimal digit ('0' to '9'), the last one flagged, and a zero
// value gives a single '0'. The converter runs its bit-serial shift-and-add-3
// loop over the VALUE_WIDTH input bits (64) and then hands the BCD word to a
// two-entry queue; it takes no new value until that word is in the queue. The
// digit sequencer behind the queue loads the word, then steps once per skipped
// leading zero and once per digit, and holds while the output is stalled, so
// the converter can take a new value while earlier ones are still printed.
// No state is kept between values and reset needs no clearing pass.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [bdascii_pkg::VALUE_PORT_W-1:0] value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [bdascii_pkg::CHAR_W-1:0]       digit_char,
	output logic                                 last
);

	logic              push_valid;
	logic              push_ready;
	bdascii_pkg::bcd_t push_bcd;
	logic              pop_valid;
	logic              pop_ready;
	bdascii_pkg::bcd_t pop_bcd;

	bdascii_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_bcd   (push_bcd)
	);

	bdascii_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_bcd   (push_bcd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_bcd    (pop_bcd)
	);

	bdascii_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_bcd    (pop_bcd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

/* rtl/bdascii_checker.sv */
// ----------------------------------------------------------------------------
// bdascii_checker
// Port-level checks on the digit stream of the decimal ASCII printer.
// ----------------------------------------------------------------------------
module bdascii_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [bdascii_pkg::CHAR_W-1:0]       digit_char,
	input logic                                 last
);

	logic                               first_q;
	logic [bdascii_pkg::REM_W-1:0]      run_cnt_q;
	logic                               out_acc;

	assign out_acc = out_valid && out_ready;

	// Track whether the next digit opens a run and how many digits came so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= 1'b1;
			run_cnt_q <= '0;
		end else if (out_acc) begin
			first_q   <= last;
			run_cnt_q <= last ? '0 : run_cnt_q + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last))
		else $error("output request changed while stalled");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= bdascii_pkg::ASCII_ZERO) &&
			(digit_char <= bdascii_pkg::ASCII_ZERO + 6'd9))
		else $error("character is not a decimal digit");

	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_q && (digit_char == bdascii_pkg::ASCII_ZERO) |-> last)
		else $error("leading zero in a run of several digits");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (run_cnt_q == bdascii_pkg::REM_W'(bdascii_pkg::NUM_DIGITS - 1)) |-> last)
		else $error("run longer than the digit limit");

endmodule

bind binary_to_decimal_ascii bdascii_checker u_bdascii_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.digit_char (digit_char),
	.last       (last)
);
